FILE: rtl/core/sce_pkg.sv
// sce_pkg: types, constants and helper functions for the shower coordinate block
// no dependencies; imported by the divider, log2 and top level files
`timescale 1ns / 1ps

package sce_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_FORMULA_MODE   = 2'd0;
  localparam logic [1:0] REG_RAD_LENGTH     = 2'd1;
  localparam logic [1:0] REG_NUCLEAR_LENGTH = 2'd2;

  // formula mode codes
  localparam logic [1:0] MODE_NEW_EM   = 2'd0;
  localparam logic [1:0] MODE_OLD_EM   = 2'd1;
  localparam logic [1:0] MODE_HADRONIC = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  // register reset values
  localparam logic [15:0] LENGTH_RESET = 16'd1517;

  // ratio divider: quotient bits and bits retired per stage
  localparam int QUO_W      = 16;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = QUO_W / DIV_BITS;

  // log2 squaring stages, one fraction bit each
  localparam int LOG_STAGES = 20;

  // fixed point constants
  localparam logic [15:0] A_MIN_Q16    = 16'd7;
  localparam logic [19:0] LN2_Q20      = 20'd726817;
  localparam logic [27:0] RECIP_237    = 28'd144977799;  // floor(2^35 / 237)
  localparam logic [7:0]  SCALE_DIV    = 8'd237;
  localparam logic [19:0] COORD_MAX    = 20'd262143;
  localparam logic [19:0] COORD_NEG_MAX = 20'd262144;

  // side band that travels with each item
  typedef struct packed {
    logic err;
    logic neg;
  } sce_meta_t;

  // partial remainder and quotient after a divider stage
  typedef struct packed {
    logic [19:0]      rem;
    logic [QUO_W-1:0] quo;
  } div_res_t;

  // restoring division, DIV_BITS quotient bits
  function automatic div_res_t div_steps(input logic [19:0] rem, input logic [19:0] den,
                                         input logic [QUO_W-1:0] quo);
    logic [20:0] r2;
    div_res_t    res;
    res.rem = rem;
    res.quo = quo;
    for (int i = 0; i < DIV_BITS; i++) begin
      r2 = {res.rem, 1'b0};
      if (r2 >= {1'b0, den}) begin
        r2      = r2 - {1'b0, den};
        res.quo = {res.quo[QUO_W-2:0], 1'b1};
      end else begin
        res.quo = {res.quo[QUO_W-2:0], 1'b0};
      end
      res.rem = r2[19:0];
    end
    return res;
  endfunction

  // Q16 coefficient of u^2
  function automatic logic [18:0] coef_sq(input logic [1:0] sel);
    case (sel)
      MODE_OLD_EM:   coef_sq = 19'd173462;
      MODE_HADRONIC: coef_sq = 19'd289103;
      default:       coef_sq = 19'd183501;
    endcase
  endfunction

  // Q16 coefficient of u
  function automatic logic [18:0] coef_lin(input logic [1:0] sel);
    case (sel)
      MODE_OLD_EM:   coef_lin = 19'd160452;
      MODE_HADRONIC: coef_lin = 19'd267420;
      default:       coef_lin = 19'd262144;
    endcase
  endfunction

endpackage

FILE: rtl/core/shower_coordinate_from_energy_ratio.sv
// shower_coordinate_from_energy_ratio: top level, config registers and arithmetic pipeline
// depends on sce_pkg, sce_divider and sce_log2
`timescale 1ns / 1ps

// Takes one pair of cell energies per clock on start (busy is always low) and
// returns the shower coordinate on done, one result per item, in order. The
// pipeline is made of the input fold register (1 stage), the ratio divider
// (8 stages of 2 bits), the -log2 unit (20 squaring stages plus normalize and
// output stages) and nine stages for the formula, length scaling, divide by
// 237 and the saturated output. The result is shown for one cycle only; the
// receiver must take it. Configuration registers are read as items pass, so
// write them only while nothing is in flight.
module shower_coordinate_from_energy_ratio
  import sce_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [19:0] left_energy,
  input  logic signed [19:0] right_energy,
  output logic               done,
  output logic signed [18:0] coordinate,
  output logic               sum_error,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int PIPE_DEPTH = 1 + DIV_STAGES + LOG_STAGES + 2 + 9;

  assign busy = 1'b0;

  // configuration registers
  logic [1:0]  formula_mode;
  logic [15:0] rad_length;
  logic [15:0] nuclear_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      formula_mode   <= MODE_NEW_EM;
      rad_length     <= LENGTH_RESET;
      nuclear_length <= LENGTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FORMULA_MODE:   formula_mode   <= cfg_data[1:0];
        REG_RAD_LENGTH:     rad_length     <= cfg_data;
        REG_NUCLEAR_LENGTH: nuclear_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // sum, error and fold of the numerators
  logic               accept;
  logic signed [20:0] sum;
  logic               sum_bad;
  logic               fold_left;
  logic signed [19:0] num;
  logic [19:0]        rem_in;
  sce_meta_t          meta_in;

  always_comb begin
    accept    = start && !busy;
    sum       = 21'(left_energy) + 21'(right_energy);
    sum_bad   = sum[20] || (sum == '0);
    fold_left = $signed({left_energy, 1'b0}) <= sum;
    num       = fold_left ? left_energy : right_energy;
    if (!sum_bad && !num[19] && (num != '0)) begin
      rem_in = {1'b0, num[18:0]};
    end else begin
      rem_in = '0;
    end
    meta_in.err = sum_bad;
    meta_in.neg = !fold_left;
  end

  logic        f_vld;
  logic [19:0] f_rem;
  logic [19:0] f_den;
  sce_meta_t   f_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else begin
      f_vld <= accept;
    end
    f_rem  <= rem_in;
    f_den  <= sum[19:0];
    f_meta <= meta_in;
  end

  // a = num * 2^16 / sum
  logic             d_vld;
  logic [QUO_W-1:0] d_quo;
  sce_meta_t        d_meta;

  sce_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_vld),
    .in_rem    (f_rem),
    .in_den    (f_den),
    .in_meta   (f_meta),
    .out_valid (d_vld),
    .out_quo   (d_quo),
    .out_meta  (d_meta)
  );

  // t = -log2(2a), Q20
  logic        l_vld;
  logic [23:0] l_t;
  sce_meta_t   l_meta;

  sce_log2 u_log2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_vld),
    .in_a      (d_quo),
    .in_meta   (d_meta),
    .out_valid (l_vld),
    .out_t     (l_t),
    .out_meta  (l_meta)
  );

  // u = t * ln2, rounded
  logic [44:0] u_prod;
  logic        u_vld;
  logic [23:0] u_val;
  sce_meta_t   u_meta;

  assign u_prod = 45'(l_t) * 45'(LN2_Q20) + 45'(1 << 19);

  always_ff @(posedge clk) begin
    if (rst) begin
      u_vld <= 1'b0;
    end else begin
      u_vld <= l_vld;
    end
    u_val  <= u_prod[43:20];
    u_meta <= l_meta;
  end

  // u2 = u * u, rounded
  logic [48:0] q_prod;
  logic        q_vld;
  logic [23:0] q_u;
  logic [26:0] q_u2;
  sce_meta_t   q_meta;

  assign q_prod = 49'(u_val) * 49'(u_val) + 49'(1 << 19);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else begin
      q_vld <= u_vld;
    end
    q_u    <= u_val;
    q_u2   <= q_prod[46:20];
    q_meta <= u_meta;
  end

  // square term with the mode coefficient
  logic [1:0]  sel;
  logic [45:0] sq_prod;
  logic        s_vld;
  logic [45:0] s_sq;
  logic [23:0] s_u;
  logic [1:0]  s_sel;
  sce_meta_t   s_meta;

  assign sel     = (formula_mode == MODE_UNUSED) ? MODE_NEW_EM : formula_mode;
  assign sq_prod = 46'(coef_sq(sel)) * 46'(q_u2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else begin
      s_vld <= q_vld;
    end
    s_sq   <= sq_prod;
    s_u    <= q_u;
    s_sel  <= sel;
    s_meta <= q_meta;
  end

  // P = square term + linear term, rounded to Q20
  logic [46:0] p_sum;
  logic        p_vld;
  logic [28:0] p_val;
  logic [1:0]  p_sel;
  sce_meta_t   p_meta;

  assign p_sum = 47'(s_sq) + 47'(coef_lin(s_sel)) * 47'(s_u) + 47'(1 << 15);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= s_vld;
    end
    p_val  <= p_sum[44:16];
    p_sel  <= s_sel;
    p_meta <= s_meta;
  end

  // P * length
  logic [15:0] len;
  logic        m_vld;
  logic [44:0] m_pl;
  sce_meta_t   m_meta;

  assign len = (p_sel == MODE_HADRONIC) ? nuclear_length : rad_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= p_vld;
    end
    m_pl   <= 45'(p_val) * 45'(len);
    m_meta <= p_meta;
  end

  // z = (10 * P * L + D / 2) >> 22, the power of two part of D
  logic [48:0] z_sum;
  logic        z_vld;
  logic [26:0] z_val;
  sce_meta_t   z_meta;

  assign z_sum = {m_pl, 3'b000} + {1'b0, m_pl, 1'b0} + (49'(SCALE_DIV) << 21);

  always_ff @(posedge clk) begin
    if (rst) begin
      z_vld <= 1'b0;
    end else begin
      z_vld <= m_vld;
    end
    z_val  <= z_sum[48:22];
    z_meta <= m_meta;
  end

  // quotient estimate z / 237 by reciprocal, low by at most one
  logic [54:0] r_prod;
  logic        e_vld;
  logic [19:0] e_q;
  logic [26:0] e_z;
  sce_meta_t   e_meta;

  assign r_prod = 55'(z_val) * 55'(RECIP_237);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= z_vld;
    end
    e_q    <= r_prod[54:35];
    e_z    <= z_val;
    e_meta <= z_meta;
  end

  // correction step on the remainder
  logic [27:0] c_back;
  logic [26:0] c_rem;
  logic        g_vld;
  logic [19:0] g_mag;
  sce_meta_t   g_meta;

  assign c_back = 28'(e_q) * 28'(SCALE_DIV);
  assign c_rem  = e_z - c_back[26:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else begin
      g_vld <= e_vld;
    end
    g_mag  <= (c_rem >= 27'(SCALE_DIV)) ? e_q + 20'd1 : e_q;
    g_meta <= e_meta;
  end

  // sign, saturation and error override
  logic [19:0] sat_mag;
  logic [18:0] coord_next;

  always_comb begin
    if (g_meta.neg) begin
      sat_mag    = (g_mag > COORD_NEG_MAX) ? COORD_NEG_MAX : g_mag;
      coord_next = 19'(20'd0 - sat_mag);
    end else begin
      sat_mag    = (g_mag > COORD_MAX) ? COORD_MAX : g_mag;
      coord_next = sat_mag[18:0];
    end
    if (g_meta.err) begin
      coord_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= g_vld;
    end
    coordinate <= coord_next;
    sum_error  <= g_meta.err;
  end

  // every result transfer traces back to an accepted item
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, PIPE_DEPTH))
    else $error("result without an accepted item");

  // error flag follows the input sum of the matching item
  a_error_matches_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (sum_error == $past(sum_bad, PIPE_DEPTH)))
    else $error("sum error does not match item");

  // error results carry a zero coordinate
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && sum_error) |-> (coordinate == '0))
    else $error("coordinate not zero on sum error");

  // a positive-side item never comes out negative
  a_sign: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(meta_in.neg, PIPE_DEPTH)) |-> !coordinate[18])
    else $error("coordinate sign flipped");

endmodule

FILE: rtl/core/sce_divider.sv
// sce_divider: pipelined restoring divider for the Q16 energy fraction
// depends on sce_pkg
`timescale 1ns / 1ps

module sce_divider
  import sce_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [19:0]      in_rem,
  input  logic [19:0]      in_den,
  input  sce_meta_t        in_meta,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo,
  output sce_meta_t        out_meta
);

  logic [DIV_STAGES-1:0] vld;
  logic [19:0]           rem  [DIV_STAGES];
  logic [19:0]           den  [DIV_STAGES];
  logic [QUO_W-1:0]      quo  [DIV_STAGES];
  sce_meta_t             meta [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic             vld_in;
    logic [19:0]      rem_in;
    logic [19:0]      den_in;
    logic [QUO_W-1:0] quo_in;
    sce_meta_t        meta_in;
    div_res_t         step;

    // stage input from the ports or the previous stage
    if (g == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_rem;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign meta_in = in_meta;
    end else begin : g_rest
      assign vld_in  = vld[g-1];
      assign rem_in  = rem[g-1];
      assign den_in  = den[g-1];
      assign quo_in  = quo[g-1];
      assign meta_in = meta[g-1];
    end

    assign step = div_steps(rem_in, den_in, quo_in);

    // stage registers
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else begin
        vld[g] <= vld_in;
      end
      rem[g]  <= step.rem;
      den[g]  <= den_in;
      quo[g]  <= step.quo;
      meta[g] <= meta_in;
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign out_quo   = quo[DIV_STAGES-1];
  assign out_meta  = meta[DIV_STAGES-1];

endmodule

FILE: rtl/core/sce_log2.sv
// sce_log2: clamp, normalize and pipelined -log2 of 2a by repeated squaring
// depends on sce_pkg
`timescale 1ns / 1ps

module sce_log2
  import sce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [15:0] in_a,
  input  sce_meta_t   in_meta,
  output logic        out_valid,
  output logic [23:0] out_t,
  output sce_meta_t   out_meta
);

  // clamp and leading one search on v = 2a
  logic [15:0] a_clamp;
  logic [16:0] v;
  logic [4:0]  msb;
  logic [3:0]  e_norm;
  logic [16:0] v_norm;

  always_comb begin
    a_clamp = (in_a < A_MIN_Q16) ? A_MIN_Q16 : in_a;
    v       = {a_clamp, 1'b0};
    msb     = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (v[i]) msb = 5'(i);
    end
    e_norm = 4'(5'd16 - msb);
    v_norm = v << e_norm;
  end

  // normalize register
  logic      n_vld;
  logic [30:0] n_m;
  logic [3:0]  n_e;
  sce_meta_t   n_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else begin
      n_vld <= in_valid;
    end
    n_m    <= {v_norm[16:0], 14'd0};
    n_e    <= e_norm;
    n_meta <= in_meta;
  end

  // squaring stages, stage g decides fraction bit LOG_STAGES-1-g
  logic [LOG_STAGES-1:0] vld;
  logic [30:0]           m    [LOG_STAGES];
  logic [LOG_STAGES-1:0] frac [LOG_STAGES];
  logic [3:0]            e    [LOG_STAGES];
  sce_meta_t             meta [LOG_STAGES];

  for (genvar g = 0; g < LOG_STAGES; g++) begin : g_sq
    logic                  vld_in;
    logic [30:0]           m_in;
    logic [LOG_STAGES-1:0] frac_in;
    logic [3:0]            e_in;
    sce_meta_t             meta_in;
    logic [61:0]           sqr;
    logic [31:0]           sh;
    logic [30:0]           m_next;
    logic [LOG_STAGES-1:0] frac_next;

    if (g == 0) begin : g_first
      assign vld_in  = n_vld;
      assign m_in    = n_m;
      assign frac_in = '0;
      assign e_in    = n_e;
      assign meta_in = n_meta;
    end else begin : g_rest
      assign vld_in  = vld[g-1];
      assign m_in    = m[g-1];
      assign frac_in = frac[g-1];
      assign e_in    = e[g-1];
      assign meta_in = meta[g-1];
    end

    // square and renormalize to [1, 2)
    always_comb begin
      sqr       = 62'(m_in) * 62'(m_in);
      sh        = sqr[61:30];
      frac_next = frac_in;
      if (sh[31]) begin
        m_next                       = sh[31:1];
        frac_next[LOG_STAGES-1-g]    = 1'b1;
      end else begin
        m_next = sh[30:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else begin
        vld[g] <= vld_in;
      end
      m[g]    <= m_next;
      frac[g] <= frac_next;
      e[g]    <= e_in;
      meta[g] <= meta_in;
    end
  end

  // t = e - fraction, Q20
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[LOG_STAGES-1];
    end
    out_t    <= {e[LOG_STAGES-1], 20'd0} - 24'(frac[LOG_STAGES-1]);
    out_meta <= meta[LOG_STAGES-1];
  end

endmodule
